// File: rtl/core/rmth_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_pkg
// shared constants, types and compare helper for the two-heap median block
// ----------------------------------------------------------------------------
package rmth_pkg;

   localparam int CAPACITY   = 1024;
   localparam int HEAP_DEPTH = (CAPACITY + 1) / 2;
   localparam int IDX_W      = $clog2(HEAP_DEPTH);
   localparam int SIZE_W     = $clog2(HEAP_DEPTH + 1);
   localparam int CH_W       = IDX_W + 2;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int DATA_W     = 32;

   typedef enum logic [2:0] {
      HP_IDLE,
      HP_UP_RD,
      HP_UP_CMP,
      HP_UP_ROOT,
      HP_DN_RD,
      HP_DN_CMP
   } heap_state_type;

   typedef enum logic [1:0] {
      CT_IDLE,
      CT_RUN,
      CT_FIN
   } ctl_state_type;

   typedef struct packed {
      logic              push;
      logic              replace;
      logic [DATA_W-1:0] value;
   } heap_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              empty;
      logic [DATA_W-1:0] top;
   } heap_stat_type;

   // true when a belongs above b in the heap
   function automatic logic above(input logic is_max, input logic [DATA_W-1:0] a,
                                  input logic [DATA_W-1:0] b);
      logic result;
      if (is_max) begin
         result = $signed(a) > $signed(b);
      end else begin
         result = $signed(a) < $signed(b);
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/rmth_heap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmth_heap
// binary heap in a synchronous memory: push with sift-up, replace-top with
// sift-down, root value cached in a register
// ----------------------------------------------------------------------------
module rmth_heap
   import rmth_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          max_order,
   input  wire heap_cmd_type  cmd,
   output      heap_stat_type stat
);

   logic [DATA_W-1:0] mem [HEAP_DEPTH];

   heap_state_type    state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  par_ff, par_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic              lok_ff, lok_in;
   logic              rok_ff, rok_in;
   logic [DATA_W-1:0] ra_ff, rb_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;

   logic [IDX_W-1:0]  par;
   logic [CH_W-1:0]   child_l, child_r;
   logic              up_move, l_up, r_up;
   logic [DATA_W-1:0] best_lv;

   assign par     = IDX_W'((idx_ff - 1'b1) >> 1);
   assign child_l = {1'b0, idx_ff, 1'b1};
   assign child_r = child_l + CH_W'(1);
   assign up_move = above(max_order, val_ff, ra_ff);
   assign l_up    = lok_ff && above(max_order, ra_ff, val_ff);
   assign best_lv = l_up ? ra_ff : val_ff;
   assign r_up    = rok_ff && above(max_order, rb_ff, best_lv);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         HP_IDLE: begin
            if (cmd.replace) begin
               state_in = HP_DN_RD;
            end else if (cmd.push && size_ff != '0) begin
               state_in = HP_UP_RD;
            end
         end
         HP_UP_RD:   state_in = HP_UP_CMP;
         HP_UP_CMP: begin
            if (!up_move) begin
               state_in = HP_IDLE;
            end else if (par_ff == '0) begin
               state_in = HP_UP_ROOT;
            end else begin
               state_in = HP_UP_RD;
            end
         end
         HP_UP_ROOT: state_in = HP_IDLE;
         HP_DN_RD:   state_in = HP_DN_CMP;
         HP_DN_CMP: begin
            if (l_up || r_up) begin
               state_in = HP_DN_RD;
            end else begin
               state_in = HP_IDLE;
            end
         end
         default:    state_in = HP_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      size_in   = size_ff;
      idx_in    = idx_ff;
      par_in    = par_ff;
      val_in    = val_ff;
      lok_in    = lok_ff;
      rok_in    = rok_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = val_ff;
      rd_a_addr = par;
      rd_b_addr = par;
      case (state_ff)
         HP_IDLE: begin
            val_in = cmd.value;
            if (cmd.replace) begin
               idx_in = '0;
            end else if (cmd.push) begin
               size_in = size_ff + SIZE_W'(1);
               idx_in  = size_ff[IDX_W-1:0];
               if (size_ff == '0) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = cmd.value;
               end
            end
         end
         HP_UP_RD: begin
            rd_a_addr = par;
            par_in    = par;
         end
         HP_UP_CMP: begin
            wr_en = 1'b1;
            if (up_move) begin
               wr_data = ra_ff;
               idx_in  = par_ff;
            end
         end
         HP_UP_ROOT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
         end
         HP_DN_RD: begin
            rd_a_addr = child_l[IDX_W-1:0];
            rd_b_addr = child_r[IDX_W-1:0];
            lok_in    = child_l < CH_W'(size_ff);
            rok_in    = child_r < CH_W'(size_ff);
         end
         HP_DN_CMP: begin
            wr_en = 1'b1;
            if (r_up) begin
               wr_data = rb_ff;
               idx_in  = child_r[IDX_W-1:0];
            end else if (l_up) begin
               wr_data = ra_ff;
               idx_in  = child_l[IDX_W-1:0];
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      top_in = (wr_en && wr_addr == '0) ? wr_data : top_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      ra_ff <= mem[rd_a_addr];
      rb_ff <= mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HP_IDLE;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
      end
      idx_ff <= idx_in;
      par_ff <= par_in;
      val_ff <= val_in;
      top_ff <= top_in;
      lok_ff <= lok_in;
      rok_ff <= rok_in;
   end

   assign stat.busy  = state_ff != HP_IDLE;
   assign stat.empty = size_ff == '0;
   assign stat.top   = top_ff;

endmodule
`default_nettype wire

// File: rtl/core/running_median_two_heaps.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_two_heaps
// running median of signed 32-bit samples kept in a max-heap and a min-heap
//
// req channel: one sample word per handshake. rsp channel: one word per
// sample with twice the median, the held count and an overflow flag.
// each sample costs at most one heap operation on each heap, run in
// parallel: a push sifts up and a replace-top sifts down, each level in a
// read state then a compare state, over 512-entry heaps. rsp_valid rises
// once both heaps are idle and the result is loaded; a dropped sample skips
// the heaps. one sample is worked on at a time; req_ready rises the
// cycle after the result is loaded; req_ready is also high while a
// finished word waits on rsp.
// once the store holds its capacity, further samples are dropped and the
// word reports the held set with overflow set.
// reset clears the count, heap sizes and the output valid flag; heap memory
// needs no clearing. a stalled rsp holds its word and the next result
// waits until the output register is free.
// ----------------------------------------------------------------------------
module running_median_two_heaps
   import rmth_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic [DATA_W-1:0] req_sample,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [DATA_W:0]   rsp_median_doubled,
   output      logic [CNT_W-1:0]  rsp_sample_count,
   output      logic              rsp_overflow
);

   ctl_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DATA_W:0]  med_ff, med_in;
   logic [CNT_W-1:0] rcnt_ff, rcnt_in;
   logic             rovf_ff, rovf_in;

   heap_cmd_type     lo_cmd, up_cmd;
   heap_stat_type    lo_stat, up_stat;
   logic             accept, full, load;

   assign accept = req_valid && req_ready;
   assign full   = count_ff == CNT_W'(CAPACITY);
   assign load   = (state_ff == CT_FIN) && (!rsp_valid_ff || rsp_ready);

   rmth_heap lower_heap (
      .clock     (clock),
      .reset     (reset),
      .max_order (1'b1),
      .cmd       (lo_cmd),
      .stat      (lo_stat)
   );

   rmth_heap upper_heap (
      .clock     (clock),
      .reset     (reset),
      .max_order (1'b0),
      .cmd       (up_cmd),
      .stat      (up_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CT_IDLE: begin
            if (accept) begin
               state_in = full ? CT_FIN : CT_RUN;
            end
         end
         CT_RUN: begin
            if (!lo_stat.busy && !up_stat.busy) begin
               state_in = CT_FIN;
            end
         end
         CT_FIN: begin
            if (load) begin
               state_in = CT_IDLE;
            end
         end
         default: state_in = CT_IDLE;
      endcase
   end

   // heap commands and result
   always_comb begin
      lo_cmd       = '0;
      up_cmd       = '0;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      med_in       = med_ff;
      rcnt_in      = rcnt_ff;
      rovf_in      = rovf_ff;
      req_ready    = state_ff == CT_IDLE;
      if (accept) begin
         ovf_in = full;
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
            if (!count_ff[0]) begin
               if (!up_stat.empty && $signed(req_sample) > $signed(up_stat.top)) begin
                  up_cmd.replace = 1'b1;
                  up_cmd.value   = req_sample;
                  lo_cmd.push    = 1'b1;
                  lo_cmd.value   = up_stat.top;
               end else begin
                  lo_cmd.push    = 1'b1;
                  lo_cmd.value   = req_sample;
               end
            end else begin
               if ($signed(req_sample) >= $signed(lo_stat.top)) begin
                  up_cmd.push    = 1'b1;
                  up_cmd.value   = req_sample;
               end else begin
                  lo_cmd.replace = 1'b1;
                  lo_cmd.value   = req_sample;
                  up_cmd.push    = 1'b1;
                  up_cmd.value   = lo_stat.top;
               end
            end
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rcnt_in      = count_ff;
         rovf_in      = ovf_ff;
         if (count_ff[0]) begin
            med_in = {lo_stat.top, 1'b0};
         end else begin
            med_in = {lo_stat.top[DATA_W-1], lo_stat.top}
                   + {up_stat.top[DATA_W-1], up_stat.top};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CT_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ovf_ff  <= ovf_in;
      med_ff  <= med_in;
      rcnt_ff <= rcnt_in;
      rovf_ff <= rovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_doubled = med_ff;
   assign rsp_sample_count   = rcnt_ff;
   assign rsp_overflow       = rovf_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("held count beyond capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second sample taken while one is in work");

   a_ovf_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_sample_count == CNT_W'(CAPACITY))
      else $error("overflow reported with store not full");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count != '0)
      else $error("result word with empty set");

endmodule
`default_nettype wire

// File: bench/tb_running_median_two_heaps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_running_median_two_heaps
// self-checking bench for the two-heap running median block
//
// samples go in over req, results come back over rsp. a behavioral model
// keeps the held set sorted and predicts twice the median, the count and the
// overflow flag per word. directed extremes first, then random phases with
// varied idling.
// ----------------------------------------------------------------------------
module tb_running_median_two_heaps;
   import rmth_pkg::*;

   typedef struct {
      logic [DATA_W:0]  med2;
      logic [CNT_W-1:0] cnt;
      logic             ovf;
   } median_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [DATA_W-1:0]   req_sample = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W:0]     rsp_median_doubled;
   logic [CNT_W-1:0]    rsp_sample_count;
   logic                rsp_overflow;
   logic                req_ready_q = 1'b0;

   logic [DATA_W-1:0]   sample_queue[$];
   median_word_type     expected_medians[$];
   int                  held_set[$];
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  errors = 0;
   int                  words_sent = 0;
   int                  words_checked = 0;
   int                  overflow_seen = 0;

   running_median_two_heaps dut (.*);

   always #5 clock = ~clock;

   // sorted insert, then median from the middle
   function automatic median_word_type predict_median(logic [DATA_W-1:0] s);
      median_word_type w;
      int v;
      int pos;
      int n;
      v = $signed(s);
      w.ovf = 1'b0;
      if (held_set.size() >= CAPACITY) begin
         w.ovf = 1'b1;
      end else begin
         pos = 0;
         while (pos < held_set.size() && held_set[pos] < v) pos++;
         held_set.insert(pos, v);
      end
      n = held_set.size();
      if (n % 2 == 1) begin
         w.med2 = 33'(2 * longint'(held_set[n / 2]));
      end else begin
         w.med2 = 33'(longint'(held_set[n / 2 - 1]) + longint'(held_set[n / 2]));
      end
      w.cnt = CNT_W'(n);
      return w;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_q) begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_sample <= sample_queue.pop_front();
               words_sent <= words_sent + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid && sample_queue.size() > 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            req_sample <= sample_queue.pop_front();
            req_valid  <= 1'b1;
            words_sent <= words_sent + 1;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // accept flag captured at the rising edge so the driver sees a stable value
   always @(posedge clock) begin
      req_ready_q <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         expected_medians.push_back(predict_median(req_sample));
      end
   end

   // monitor
   always @(posedge clock) begin
      median_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked <= words_checked + 1;
         if (expected_medians.size() == 0) begin
            $error("unexpected rsp word");
            errors <= errors + 1;
         end else begin
            e = expected_medians.pop_front();
            if (rsp_overflow) overflow_seen <= overflow_seen + 1;
            if (rsp_median_doubled !== e.med2) begin
               $error("median_doubled: expected %0d got %0d", $signed(e.med2),
                      $signed(rsp_median_doubled));
               errors <= errors + 1;
            end
            if (rsp_sample_count !== e.cnt) begin
               $error("sample_count: expected %0d got %0d", e.cnt, rsp_sample_count);
               errors <= errors + 1;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow: expected %0d got %0d", e.ovf, rsp_overflow);
               errors <= errors + 1;
            end
         end
      end
   end

   task automatic drain_phase();
      while (sample_queue.size() > 0 || req_valid || expected_medians.size() > 0)
         @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] rand_sample();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7fff_ffff - $urandom_range(3);
         2: return $urandom_range(20) - 10;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int pidle[4] = '{0, 76, 0, 12};
      int pstall[4] = '{0, 0, 76, 12};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // directed extremes, ties and alternating signs
      sample_queue = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                       32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'hffff_ffff,
                       32'h1, 32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'h7fff_ffff,
                       32'h8000_0000, 32'h0000_0005};
      drain_phase();
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = pidle[p];
         recv_stall_pct = pstall[p];
         for (int i = 0; i < 96; i++) sample_queue.push_back(rand_sample());
         drain_phase();
      end
      repeat (50) @(posedge clock);
      $display("sent %0d samples, checked %0d words, %0d with overflow",
               words_sent, words_checked, overflow_seen);
      $display("covered extremes, ties and four idling phases on a growing set");
      if (errors == 0 && expected_medians.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
